// File: rtl/core/fap_pkg.sv
// Shared types, constants and reset values of the framed ASCII field parser.
package fap_pkg;

    // Default size of the frame body buffer, in bytes
    localparam int BUFFER_SIZE_DEF = 64;
    // Number of decimal fields the parser can hold
    localparam int FIELD_COUNT     = 4;

    // Register reset values
    localparam logic [7:0] START_BYTE_RST  = 8'd64;  // '@'
    localparam logic [7:0] END_BYTE_RST    = 8'd35;  // '#'
    localparam logic [6:0] MIN_LENGTH_RST  = 7'd7;
    localparam logic [2:0] FIELDS_USED_RST = 3'd4;

    // Character codes used by the scanner
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_PLUS     = 8'd43;
    localparam logic [7:0] CH_COMMA    = 8'd44;
    localparam logic [7:0] CH_MINUS    = 8'd45;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_NINE     = 8'd57;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_START_BYTE  = 2'd0,
        REG_END_BYTE    = 2'd1,
        REG_MIN_LENGTH  = 2'd2,
        REG_FIELDS_USED = 2'd3
    } t_reg_index;

    // Scanner phases
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_scan_phase;

    typedef logic signed [15:0] t_value;

    // One result as held in the output register
    typedef struct packed {
        t_value     first_value;
        t_value     second_value;
        t_value     third_value;
        t_value     fourth_value;
        logic [2:0] fields_converted;
        logic       length_accepted;
    } t_result;

endpackage

// File: rtl/core/fap_if.sv
// Channel interfaces of the framed ASCII field parser: bytes, results, configuration.
interface fap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fap_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic signed [15:0] third_value;
    logic signed [15:0] fourth_value;
    logic [2:0]         fields_converted;
    logic               length_accepted;

    modport source (output valid, output first_value, output second_value,
                    output third_value, output fourth_value,
                    output fields_converted, output length_accepted, input ready);
    modport sink   (input valid, input first_value, input second_value,
                    input third_value, input fourth_value,
                    input fields_converted, input length_accepted, output ready);
endinterface

interface fap_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [7:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/core/framed_ascii_csv_int_parser_top.sv
// Top level of the framed ASCII comma-separated decimal field parser.
//
//  port    | dir | request carries                         | handshake
//  --------+-----+-----------------------------------------+-------------
//  i_in    | in  | rx_byte, one received byte              | valid/ready
//  o_res   | out | four held values, fields_converted, ok  | valid/ready
//  i_cfg   | in  | reg_index, wr_data                      | valid/ready
//
//  One byte is taken per cycle while i_in.ready is high; its scan step and any commit finish in that cycle,
//  so a result appears in the output register on the edge after the end byte.
//  Throughput is one byte per cycle, limited only by the single output register.
//  i_in.ready drops only while a result sits in the output register and o_res.ready is low.
//  Reset (synchronous, active low) clears the frame state, held values and registers.
//  Configuration writes are always taken.
module framed_ascii_csv_int_parser_top #(
    parameter int BUFFER_SIZE = fap_pkg::BUFFER_SIZE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fap_byte_if.sink     i_in,
    fap_result_if.source o_res,
    fap_cfg_if.sink      i_cfg
);
    import fap_pkg::*;

    localparam int CW = $clog2(BUFFER_SIZE + 1);
    localparam int SW = (CW + 1 > 7) ? CW + 1 : 7;

    // Configuration registers
    logic [7:0] r_start_byte;
    logic [7:0] r_end_byte;
    logic [6:0] r_min_length;
    logic [2:0] r_fields_used;

    // Frame and scanner state
    logic          r_in_frame, n_in_frame;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]    r_fidx, n_fidx;
    t_scan_phase   r_phase, n_phase;
    logic          r_neg, n_neg;
    logic [15:0]   r_acc, n_acc;
    t_value        r_pend [FIELD_COUNT];
    t_value        n_pend [FIELD_COUNT];
    t_value        r_held [FIELD_COUNT];
    t_value        n_held [FIELD_COUNT];

    // Output register
    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;

    // Scanner outputs for the current character
    logic [7:0]  scan_c;
    logic        scan_en;
    logic [2:0]  lim;
    logic        is_digit, is_space;
    logic [15:0] digit_val;
    logic [2:0]  sc_fidx;
    t_scan_phase sc_phase;
    logic        sc_neg;
    logic [15:0] sc_acc;
    t_value      sc_pend [FIELD_COUNT];

    // Commit signals
    logic          emit;
    logic [SW-1:0] stored;
    logic          len_ok;
    logic [2:0]    conv;

    logic in_fire;
    logic out_fire;

    assign i_in.ready  = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_fire    = r_out_valid && o_res.ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RST;
            r_end_byte    <= END_BYTE_RST;
            r_min_length  <= MIN_LENGTH_RST;
            r_fields_used <= FIELDS_USED_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg_index'(i_cfg.reg_index))
                REG_START_BYTE:  r_start_byte  <= i_cfg.wr_data;
                REG_END_BYTE:    r_end_byte    <= i_cfg.wr_data;
                REG_MIN_LENGTH:  r_min_length  <= i_cfg.wr_data[6:0];
                REG_FIELDS_USED: r_fields_used <= i_cfg.wr_data[2:0];
                default: ;
            endcase
        end
    end

    // Classify the character and clamp the field limit
    assign lim       = (r_fields_used > 3'(FIELD_COUNT)) ? 3'(FIELD_COUNT) : r_fields_used;
    assign is_digit  = (scan_c >= CH_ZERO) && (scan_c <= CH_NINE);
    assign is_space  = (scan_c == CH_SPACE) || ((scan_c >= CH_TAB) && (scan_c <= CH_CR));
    assign digit_val = {8'd0, scan_c - CH_ZERO};

    // Advance the scanner by one character
    always_comb begin
        sc_fidx  = r_fidx;
        sc_phase = r_phase;
        sc_neg   = r_neg;
        sc_acc   = r_acc;
        sc_pend  = r_pend;
        if (r_phase != PH_DONE && r_fidx >= lim) begin
            sc_phase = PH_DONE;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (is_space) begin
                        sc_phase = PH_START;
                    end else if (scan_c == CH_PLUS || scan_c == CH_MINUS) begin
                        sc_neg   = (scan_c == CH_MINUS);
                        sc_phase = PH_SIGN;
                    end else if (is_digit) begin
                        sc_neg   = 1'b0;
                        sc_acc   = digit_val;
                        sc_phase = PH_DIGITS;
                    end else begin
                        sc_phase = PH_DONE;
                    end
                end
                PH_SIGN: begin
                    if (is_digit) begin
                        sc_acc   = digit_val;
                        sc_phase = PH_DIGITS;
                    end else begin
                        sc_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        sc_acc = 16'(r_acc * 16'd10 + digit_val);
                    end else begin
                        sc_pend[r_fidx[1:0]] = r_neg ? t_value'(16'd0 - r_acc)
                                                     : t_value'(r_acc);
                        sc_fidx  = r_fidx + 3'd1;
                        sc_acc   = 16'd0;
                        sc_neg   = 1'b0;
                        sc_phase = (scan_c == CH_COMMA && (r_fidx + 3'd1) < lim)
                                   ? PH_START : PH_DONE;
                    end
                end
                default: sc_phase = PH_DONE;
            endcase
        end
    end

    // Frame control, commit and result capture
    always_comb begin
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_fidx      = r_fidx;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_held      = r_held;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        scan_c      = i_in.rx_byte;
        scan_en     = 1'b0;
        emit        = 1'b0;

        if (in_fire && r_in_frame) begin
            if (i_in.rx_byte != r_end_byte) begin
                scan_en = (r_count < CW'(BUFFER_SIZE));
            end else begin
                scan_c  = CH_NEWLINE;
                scan_en = 1'b1;
                emit    = 1'b1;
            end
        end

        stored = ((SW'(r_count) + SW'(1)) > SW'(BUFFER_SIZE)) ? SW'(BUFFER_SIZE)
                                                              : SW'(r_count) + SW'(1);
        len_ok = (stored >= SW'(r_min_length));
        conv   = len_ok ? ((sc_fidx > 3'(FIELD_COUNT)) ? 3'(FIELD_COUNT) : sc_fidx) : 3'd0;

        if (scan_en) begin
            n_count = r_count + CW'(1);
            n_fidx  = sc_fidx;
            n_phase = sc_phase;
            n_neg   = sc_neg;
            n_acc   = sc_acc;
            n_pend  = sc_pend;
        end

        if (in_fire && !r_in_frame && i_in.rx_byte == r_start_byte) begin
            n_in_frame = 1'b1;
            n_count    = '0;
            n_fidx     = 3'd0;
            n_phase    = PH_START;
            n_neg      = 1'b0;
            n_acc      = 16'd0;
        end

        if (emit) begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
                if (3'(i) < conv) begin
                    n_held[i] = sc_pend[i];
                end
            end
            n_in_frame             = 1'b0;
            n_count                = '0;
            n_fidx                 = 3'd0;
            n_phase                = PH_START;
            n_neg                  = 1'b0;
            n_acc                  = 16'd0;
            n_out_valid            = 1'b1;
            n_out.first_value      = n_held[0];
            n_out.second_value     = n_held[1];
            n_out.third_value      = n_held[2];
            n_out.fourth_value     = n_held[3];
            n_out.fields_converted = conv;
            n_out.length_accepted  = len_ok;
        end
    end

    // Hold state; clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_fidx      <= 3'd0;
            r_phase     <= PH_START;
            r_neg       <= 1'b0;
            r_acc       <= 16'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                r_pend[i] <= '0;
                r_held[i] <= '0;
            end
        end else begin
            r_in_frame  <= n_in_frame;
            r_count     <= n_count;
            r_fidx      <= n_fidx;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_held      <= n_held;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.first_value      = r_out.first_value;
    assign o_res.second_value     = r_out.second_value;
    assign o_res.third_value      = r_out.third_value;
    assign o_res.fourth_value     = r_out.fourth_value;
    assign o_res.fields_converted = r_out.fields_converted;
    assign o_res.length_accepted  = r_out.length_accepted;

`ifndef SYNTHESIS
    // A rejected length never reports converted fields
    a_reject_no_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.length_accepted || r_out.fields_converted == 3'd0))
        else $error("fields reported for a rejected frame");

    // Idle state carries no frame leftovers
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_count == '0 && r_fidx == 3'd0 && r_phase == PH_START))
        else $error("frame state not cleared while idle");

    // The body count saturates at the buffer size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_SIZE))
        else $error("byte count beyond buffer size");

    // An end byte inside a frame always loads a result
    a_end_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_in_frame && i_in.rx_byte == r_end_byte) |=> (r_out_valid && !r_in_frame))
        else $error("end byte did not produce a result");
`endif

endmodule

// File: verif/tb_framed_ascii_csv_int_parser_top.sv
// Testbench of the framed ASCII field parser: framed decimal text checked against a local parse model.
`timescale 1ns / 100ps

module tb_framed_ascii_csv_int_parser_top;
    import fap_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES     = 300;
    localparam int BYTES_PER_PHASE = 140;
    localparam int PHASE_COUNT     = 8;
    localparam int MAX_PRINTED     = 100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fap_byte_if   byte_ch ();
    fap_result_if res_ch ();
    fap_cfg_if    cfg_ch ();

    framed_ascii_csv_int_parser_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Register copies of the parse model
    logic [7:0]  set_start;
    logic [7:0]  set_end;
    logic [6:0]  set_min_len;
    logic [2:0]  set_fields;

    // Frame and scanner state of the parse model
    logic        frame_open;
    int          body_count;
    int          field_pos;
    t_scan_phase scan_ph;
    logic        minus_seen;
    logic [15:0] digit_acc;
    logic [15:0] field_buf [4];
    logic [15:0] held_buf [4];

    t_result     frame_results_due [$];
    logic [7:0]  bytes_pending [$];
    int          bytes_queued  = 0;
    int          bytes_taken   = 0;
    int          error_count   = 0;
    int          src_busy_pct  = 30;
    int          sink_busy_pct = 30;
    int          src_gap       = 0;
    int          sink_stall    = 0;
    int          cycle_count   = 0;
    logic        hold_go       = 1'b0;
    logic        rx_hold       = 1'b0;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Restart the number scan for a new frame
    function automatic void clear_scan();
        field_pos  = 0;
        scan_ph    = PH_START;
        minus_seen = 1'b0;
        digit_acc  = '0;
    endfunction

    function automatic void reset_model();
        int i;
        set_start   = START_BYTE_RST;
        set_end     = END_BYTE_RST;
        set_min_len = MIN_LENGTH_RST;
        set_fields  = FIELDS_USED_RST;
        frame_open  = 1'b0;
        body_count  = 0;
        clear_scan();
        for (i = 0; i < FIELD_COUNT; i++) begin
            field_buf[i] = '0;
            held_buf[i]  = '0;
        end
    endfunction

    function automatic void apply_reg(t_reg_index idx, logic [7:0] val);
        case (idx)
            REG_START_BYTE:  set_start   = val;
            REG_END_BYTE:    set_end     = val;
            REG_MIN_LENGTH:  set_min_len = val[6:0];
            REG_FIELDS_USED: set_fields  = val[2:0];
            default: ;
        endcase
    endfunction

    // Advance the decimal scan by one body character
    function automatic void scan_body_char(logic [7:0] c);
        logic        is_digit;
        logic        is_space;
        logic [15:0] value;
        int          cap;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        cap      = (set_fields > FIELD_COUNT) ? FIELD_COUNT : int'(set_fields);
        // stop once every allowed field has been taken
        if (scan_ph != PH_DONE && field_pos >= cap) begin
            scan_ph = PH_DONE;
            return;
        end
        case (scan_ph)
            PH_START: begin
                if (is_space) begin
                    // skip leading whitespace
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    minus_seen = (c == CH_MINUS);
                    scan_ph    = PH_SIGN;
                end else if (is_digit) begin
                    minus_seen = 1'b0;
                    digit_acc  = 16'(c - CH_ZERO);
                    scan_ph    = PH_DIGITS;
                end else begin
                    scan_ph = PH_DONE;
                end
            end
            PH_SIGN: begin
                if (is_digit) begin
                    digit_acc = 16'(c - CH_ZERO);
                    scan_ph   = PH_DIGITS;
                end else begin
                    scan_ph = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    digit_acc = digit_acc * 16'd10 + 16'(c - CH_ZERO);
                end else begin
                    // close the number, wrapping the negation to 16 bits
                    value = minus_seen ? (16'd0 - digit_acc) : digit_acc;
                    field_buf[field_pos % FIELD_COUNT] = value;
                    field_pos++;
                    digit_acc  = '0;
                    minus_seen = 1'b0;
                    scan_ph    = (c == CH_COMMA && field_pos < cap) ? PH_START : PH_DONE;
                end
            end
            default: scan_ph = PH_DONE;
        endcase
    endfunction

    // Work out the effect of one accepted byte; a closing byte adds a due result
    function automatic void parse_byte(logic [7:0] b);
        int      stored;
        int      conv;
        int      i;
        logic    accept;
        t_result res;
        if (!frame_open) begin
            if (b == set_start) begin
                frame_open = 1'b1;
                body_count = 0;
                clear_scan();
            end
            return;
        end
        if (b != set_end) begin
            // drop body bytes once the buffer is full
            if (body_count < BUFFER_SIZE_DEF) begin
                body_count++;
                scan_body_char(b);
            end
            return;
        end
        // the end byte ends a number in progress as a newline would
        scan_body_char(CH_NEWLINE);
        stored = (body_count + 1 > BUFFER_SIZE_DEF) ? BUFFER_SIZE_DEF : body_count + 1;
        accept = (stored >= set_min_len);
        conv   = 0;
        if (accept) begin
            conv = (field_pos > FIELD_COUNT) ? FIELD_COUNT : field_pos;
            for (i = 0; i < conv; i++) held_buf[i] = field_buf[i];
        end
        frame_open = 1'b0;
        body_count = 0;
        clear_scan();
        res.first_value      = held_buf[0];
        res.second_value     = held_buf[1];
        res.third_value      = held_buf[2];
        res.fourth_value     = held_buf[3];
        res.fields_converted = 3'(conv);
        res.length_accepted  = accept;
        frame_results_due.push_back(res);
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int idle_gap(int busy_pct);
        int roll;
        if ($urandom_range(0, 99) >= busy_pct) return 0;
        roll = $urandom_range(0, 9);
        if (roll < 7) return $urandom_range(1, 3);
        if (roll < 9) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic void queue_byte(logic [7:0] b);
        bytes_pending.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void queue_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) queue_byte(s[i]);
    endfunction

    function automatic void queue_frame(string body_text);
        queue_byte(set_start);
        queue_text(body_text);
        queue_byte(set_end);
    endfunction

    // Queue one random frame; return the number of frame bytes queued
    function automatic int queue_random_frame();
        logic [7:0] body [$];
        logic [7:0] ws_chars [6];
        int         kind;
        int         n_fields;
        int         n_digits;
        int         pos;
        int         i;
        int         k;
        logic       close_it;
        ws_chars = '{CH_SPACE, CH_TAB, CH_NEWLINE, 8'd11, 8'd12, CH_CR};
        kind     = $urandom_range(0, 99);
        close_it = 1'b1;
        // stray bytes on the idle line
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
        if (kind < 95) begin
            // well-formed comma-separated numbers
            n_fields = $urandom_range(1, 5);
            for (i = 0; i < n_fields; i++) begin
                if (i > 0) body.push_back(CH_COMMA);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) body.push_back(ws_chars[$urandom_range(0, 5)]);
                k = $urandom_range(0, 3);
                if (k == 0) body.push_back(CH_MINUS);
                else if (k == 1) body.push_back(CH_PLUS);
                n_digits = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(1, 4);
                repeat (n_digits) body.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            // spoil about a fifth of them
            if (kind >= 75) begin
                pos = $urandom_range(0, body.size() - 1);
                case ($urandom_range(0, 5))
                    0: body[pos] = 8'($urandom);
                    1: begin
                        body.insert(pos, CH_COMMA);
                        body.insert(pos, CH_MINUS);
                    end
                    2: begin
                        body.insert(pos, CH_COMMA);
                        body.insert(pos, CH_COMMA);
                    end
                    3: body.insert(pos, 8'h00);
                    4: body.insert(pos, 8'(8'd97 + $urandom_range(0, 25)));
                    default: close_it = 1'b0;
                endcase
            end
        end else begin
            // overlong body that can run past the buffer
            repeat ($urandom_range(56, 90))
                body.push_back(($urandom_range(0, 3) == 0) ? CH_COMMA
                                                           : 8'(CH_ZERO + $urandom_range(0, 9)));
        end
        queue_byte(set_start);
        foreach (body[j]) queue_byte(body[j]);
        if (close_it) queue_byte(set_end);
        return body.size() + (close_it ? 2 : 1);
    endfunction

    // Wait until every byte is taken, every result is in and no frame is left open
    task automatic drain();
        forever begin
            while (!(bytes_taken == bytes_queued && frame_results_due.size() == 0))
                @(negedge i_clk);
            if (!frame_open) break;
            queue_byte(set_end);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four registers back to back; call at a rising edge
    task automatic load_settings(logic [7:0] start_val, logic [7:0] end_val,
                                 logic [7:0] min_val, logic [7:0] fields_val);
        logic [7:0] vals [4];
        t_reg_index idx;
        int         i;
        vals = '{start_val, end_val, min_val, fields_val};
        for (i = 0; i < 4; i++) begin
            idx = t_reg_index'(i);
            cfg_ch.valid     <= 1'b1;
            cfg_ch.reg_index <= idx;
            cfg_ch.wr_data   <= vals[i];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            apply_reg(idx, vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Byte driver: offer queued bytes, hold each until its request is taken
    always @(posedge i_clk) begin : byte_driver
        logic offering;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            offering = byte_ch.valid;
            if (byte_ch.valid && byte_ch.ready) begin
                parse_byte(byte_ch.rx_byte);
                bytes_taken++;
                offering = 1'b0;
            end
            if (offering) begin
                // hold the current request
            end else if (src_gap > 0) begin
                src_gap--;
                byte_ch.valid <= 1'b0;
            end else if (bytes_pending.size() > 0) begin
                byte_ch.valid   <= 1'b1;
                byte_ch.rx_byte <= bytes_pending.pop_front();
                src_gap = idle_gap(src_busy_pct);
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each taken result with the oldest one due
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (frame_results_due.size() == 0) begin
                    report_mismatch("result with nothing due", 1, 0);
                end else begin
                    want = frame_results_due.pop_front();
                    if (res_ch.first_value !== want.first_value)
                        report_mismatch("first_value", res_ch.first_value, want.first_value);
                    if (res_ch.second_value !== want.second_value)
                        report_mismatch("second_value", res_ch.second_value,
                                        want.second_value);
                    if (res_ch.third_value !== want.third_value)
                        report_mismatch("third_value", res_ch.third_value, want.third_value);
                    if (res_ch.fourth_value !== want.fourth_value)
                        report_mismatch("fourth_value", res_ch.fourth_value,
                                        want.fourth_value);
                    if (res_ch.fields_converted !== want.fields_converted)
                        report_mismatch("fields_converted", res_ch.fields_converted,
                                        want.fields_converted);
                    if (res_ch.length_accepted !== want.length_accepted)
                        report_mismatch("length_accepted", res_ch.length_accepted,
                                        want.length_accepted);
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                res_ch.ready <= 1'b0;
            end else begin
                sink_stall = idle_gap(sink_busy_pct);
                res_ch.ready <= (sink_stall == 0) && !rx_hold;
            end
        end
    end

    // Long hold-off on the result side so the output fills and the input stalls
    initial begin : long_sink_hold
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Run-time limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int phase_bytes;
        byte_ch.valid    = 1'b0;
        byte_ch.rx_byte  = '0;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = REG_START_BYTE;
        cfg_ch.wr_data   = '0;
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames under the reset settings
        queue_frame("32767,-32768,0,+5");
        queue_frame("1");
        queue_frame(" \t+12, -7 ,9,1");
        queue_frame("99999,-65536,123456,-0");
        queue_frame("  -,5,6,7");
        queue_byte(set_start);
        queue_text("12,");
        queue_byte(8'h00);
        queue_text(" 3,4");
        queue_byte(set_end);
        queue_frame("1,2,3,4,5,6");
        queue_text("xyz#!");
        queue_frame("1,@2,3");
        queue_byte(set_start);
        queue_text("1,2,3,");
        repeat (70) queue_byte("4");
        queue_byte(set_end);
        queue_byte(set_start);
        queue_text("5,6");
        queue_frame("7,8,9");
        drain();

        // Start equal to end, no fields, no length floor
        load_settings(8'h7E, 8'h7E, 8'd0, 8'd0);
        @(negedge i_clk);
        queue_frame("12,3");
        queue_byte(set_start);
        queue_byte(set_end);
        drain();

        // Full buffer exactly at the minimum, and one byte short of it
        load_settings(8'h00, 8'hFF, 8'd64, 8'd7);
        @(negedge i_clk);
        queue_byte(set_start);
        queue_text("-1,-2,-3,-4,-5");
        repeat (49) queue_byte(CH_SPACE);
        queue_byte(set_end);
        queue_byte(set_start);
        queue_text("-1,-2,-3,-4,-5");
        repeat (48) queue_byte(CH_SPACE);
        queue_byte(set_end);
        drain();

        // Minimum that no frame can reach
        load_settings(8'hFF, 8'h00, 8'd127, 8'd1);
        @(negedge i_clk);
        queue_frame("55");
        queue_frame("-9,8");
        drain();

        // Random frames under a run of settings
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    load_settings(START_BYTE_RST, END_BYTE_RST, 8'd7, 8'd4);
                    src_busy_pct  = 30;
                    sink_busy_pct = 30;
                end
                1: begin
                    load_settings("{", "}", 8'd0, 8'd1);
                    src_busy_pct  = 0;
                    sink_busy_pct = 0;
                end
                2: begin
                    load_settings(START_BYTE_RST, END_BYTE_RST, 8'd12, 8'd4);
                    src_busy_pct  = 0;
                    sink_busy_pct = 20;
                end
                3: begin
                    load_settings(8'h00, 8'hFF, 8'd1, 8'd2);
                    src_busy_pct  = 50;
                    sink_busy_pct = 10;
                end
                4: begin
                    load_settings("$", CH_NEWLINE, 8'd9, 8'd3);
                    src_busy_pct  = 10;
                    sink_busy_pct = 50;
                end
                5: begin
                    load_settings("S", "S", 8'd5, 8'd7);
                    src_busy_pct  = 30;
                    sink_busy_pct = 30;
                end
                6: begin
                    load_settings(8'($urandom), 8'($urandom), 8'($urandom_range(0, 20)),
                                  8'($urandom_range(0, 7)));
                    src_busy_pct  = 20;
                    sink_busy_pct = 20;
                end
                default: begin
                    // upper data bits above each register's width are dropped
                    load_settings(8'hFF, 8'h00, 8'hC1, 8'hFC);
                    src_busy_pct  = 30;
                    sink_busy_pct = 30;
                end
            endcase
            @(negedge i_clk);
            if (phase == 2) hold_go = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE) phase_bytes += queue_random_frame();
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
